/* sv/rcthr_pkg.sv */
// ----------------------------------------------------------------------------
// Rumble command throttler package
// Shared types, register indexes and constants for the throttler blocks.
// ----------------------------------------------------------------------------
package rcthr_pkg;

	localparam int LevelW    = 7;
	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 10;
	localparam int TicksW    = 10;

	localparam int MaxDelayTicksDefault = 1000;
	localparam int QueueDepthDefault    = 2;

	localparam logic [CfgIndexW-1:0] CFG_ATT_MAIN     = 3'd0;
	localparam logic [CfgIndexW-1:0] CFG_ATT_TRIGGERS = 3'd1;
	localparam logic [CfgIndexW-1:0] CFG_TRIGGER_MODE = 3'd2;
	localparam logic [CfgIndexW-1:0] CFG_QUIRK_FLAGS  = 3'd3;
	localparam logic [CfgIndexW-1:0] CFG_THROTTLE     = 3'd4;

	localparam logic [TicksW-1:0] ThrottleReset = 10'd50;

	localparam int QuirkNoPulse   = 0;
	localparam int QuirkNoTrigger = 1;
	localparam int QuirkNoMask    = 2;
	localparam int QuirkReverse   = 3;
	localparam int QuirkSwap      = 4;

	localparam logic [7:0] TriggerModeOff = 8'd2;
	localparam logic [7:0] PulseSustainOn = 8'hFF;
	localparam logic [7:0] LoopCountOn    = 8'hEB;

	localparam int LevelMax = 100;

	typedef logic [LevelW-1:0] level_t;

	typedef struct packed {
		logic [7:0]        att_main;
		logic [7:0]        att_triggers;
		logic [7:0]        trigger_mode;
		logic [4:0]        quirk_flags;
		logic [TicksW-1:0] throttle_ticks;
	} cfg_t;

	typedef struct packed {
		logic   is_tick;
		level_t strong_lvl;
		level_t weak_lvl;
		level_t left;
		level_t right;
	} cmd_t;

endpackage

/* sv/rumble_command_throttler_core.sv */
// ----------------------------------------------------------------------------
// Rumble command throttler core
// Each transaction on the input is either a rumble request or one time tick.
// A request is scaled to four motor levels (0 to 100) by the front end in
// a sequence of states: capture, six multiply or divide steps and the push
// into the queue; a tick goes from capture straight to the push. The front
// end takes one transaction at a time, so the input stays stalled until the
// command is pushed, which waits while the queue is full.
// Commands then wait in a small queue, and the back end retires one per
// cycle while its output register is free, applying the running-maximum
// pending levels, the throttle and send countdowns and the change mask.
// A report transaction appears only when some motor level changed since the
// last report. Configuration is written through the plain write port.
// ----------------------------------------------------------------------------
module rumble_command_throttler_core #(
	parameter int MAX_DELAY_TICKS = rcthr_pkg::MaxDelayTicksDefault,
	parameter int QUEUE_DEPTH     = rcthr_pkg::QueueDepthDefault
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write_en,
	input  logic [rcthr_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [rcthr_pkg::CfgDataW-1:0]     cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               req_type,
	input  logic [15:0]                        weak_request,
	input  logic [15:0]                        strong_request,
	input  logic [9:0]                         left_trigger_pressure,
	input  logic [9:0]                         right_trigger_pressure,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [3:0]                         motor_enable_mask,
	output logic [6:0]                         strong_level,
	output logic [6:0]                         weak_level,
	output logic [6:0]                         left_level,
	output logic [6:0]                         right_level,
	output logic [7:0]                         pulse_sustain,
	output logic [7:0]                         pulse_loops
);

	rcthr_pkg::cfg_t cfg_q;
	rcthr_pkg::cmd_t push_cmd, pop_cmd;
	logic            push_valid, push_ready, pop_valid, pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.att_main       <= '0;
			cfg_q.att_triggers   <= '0;
			cfg_q.trigger_mode   <= '0;
			cfg_q.quirk_flags    <= '0;
			cfg_q.throttle_ticks <= rcthr_pkg::ThrottleReset;
		end else if (cfg_write_en) begin
			case (cfg_index)
				rcthr_pkg::CFG_ATT_MAIN:     cfg_q.att_main       <= cfg_data[7:0];
				rcthr_pkg::CFG_ATT_TRIGGERS: cfg_q.att_triggers   <= cfg_data[7:0];
				rcthr_pkg::CFG_TRIGGER_MODE: cfg_q.trigger_mode   <= cfg_data[7:0];
				rcthr_pkg::CFG_QUIRK_FLAGS:  cfg_q.quirk_flags    <= cfg_data[4:0];
				rcthr_pkg::CFG_THROTTLE:     cfg_q.throttle_ticks <= cfg_data[9:0];
				default: begin
				end
			endcase
		end
	end

	rcthr_front u_front (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.in_valid               (in_valid),
		.in_stall               (in_stall),
		.req_type               (req_type),
		.weak_request           (weak_request),
		.strong_request         (strong_request),
		.left_trigger_pressure  (left_trigger_pressure),
		.right_trigger_pressure (right_trigger_pressure),
		.cfg                    (cfg_q),
		.push_valid             (push_valid),
		.push_ready             (push_ready),
		.push_cmd               (push_cmd)
	);

	rcthr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	rcthr_back #(
		.MAX_DELAY_TICKS (MAX_DELAY_TICKS)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.pop_valid         (pop_valid),
		.pop_ready         (pop_ready),
		.pop_cmd           (pop_cmd),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.motor_enable_mask (motor_enable_mask),
		.strong_level      (strong_level),
		.weak_level        (weak_level),
		.left_level        (left_level),
		.right_level       (right_level),
		.pulse_sustain     (pulse_sustain),
		.pulse_loops       (pulse_loops)
	);

	a_front_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("front end took a second transaction while scaling");

	a_levels_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> strong_level <= 7'(rcthr_pkg::LevelMax)
			&& weak_level <= 7'(rcthr_pkg::LevelMax)
			&& left_level <= 7'(rcthr_pkg::LevelMax)
			&& right_level <= 7'(rcthr_pkg::LevelMax))
		else $error("report carries a motor level above full scale");

	a_report_enables_motor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> motor_enable_mask != 4'd0)
		else $error("report sent with no motor enabled");

endmodule

/* sv/rcthr_front.sv */
// ----------------------------------------------------------------------------
// Rumble throttler front end
// Accepts requests and ticks, scales a request to four motor levels over a
// short sequence of multiply and divide steps, and queues the command.
// ----------------------------------------------------------------------------
module rcthr_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                req_type,
	input  logic [15:0]         weak_request,
	input  logic [15:0]         strong_request,
	input  logic [9:0]          left_trigger_pressure,
	input  logic [9:0]          right_trigger_pressure,
	input  rcthr_pkg::cfg_t     cfg,
	output logic                push_valid,
	input  logic                push_ready,
	output rcthr_pkg::cmd_t     push_cmd
);

	typedef enum logic [7:0] {
		F_IDLE    = 8'b00000001,
		F_PT_MUL  = 8'b00000010,
		F_PT_DIV  = 8'b00000100,
		F_TRG_MUL = 8'b00001000,
		F_TRG_DIV = 8'b00010000,
		F_LVL_MUL = 8'b00100000,
		F_LVL_DIV = 8'b01000000,
		F_PUSH    = 8'b10000000
	} front_state_t;

	localparam logic [7:0]  Percent    = 8'd100;
	localparam logic [12:0] Div100Mul  = 13'd5243;
	localparam int          Div100Shft = 19;
	localparam logic [16:0] RoundTrig  = 17'd511;
	localparam logic [22:0] RoundLvl   = 23'd32767;

	function automatic rcthr_pkg::level_t clamp_pct(input logic [7:0] att);
		return (att >= Percent) ? '0 : rcthr_pkg::LevelW'(Percent - att);
	endfunction

	// The quotient stays at or below 100, so one correction step is exact.
	function automatic rcthr_pkg::level_t div1023(input logic [16:0] n);
		logic [6:0]  q0;
		logic [10:0] r;
		q0 = n[16:10];
		r  = {1'b0, n[9:0]} + 11'(q0);
		return (r >= 11'd1023) ? q0 + 7'd1 : q0;
	endfunction

	function automatic rcthr_pkg::level_t div65535(input logic [22:0] n);
		logic [6:0]  q0;
		logic [16:0] r;
		q0 = n[22:16];
		r  = {1'b0, n[15:0]} + 17'(q0);
		return (r >= 17'd65535) ? q0 + 7'd1 : q0;
	endfunction

	front_state_t state_q, state_d;

	logic               is_tick_q;
	logic [15:0]        weak_q, strong_q;
	logic [9:0]         lz_q, rz_q;
	logic [13:0]        prod_pt_q;
	rcthr_pkg::level_t  pt_q, tl_q, tr_q;
	logic [16:0]        trg_l_q, trg_r_q;
	logic [22:0]        prod_s_q, prod_w_q, prod_l_q, prod_r_q;
	rcthr_pkg::level_t  lvl_s_q, lvl_w_q, lvl_l_q, lvl_r_q;

	rcthr_pkg::level_t  pm, ct;
	logic [26:0]        pt_full;
	logic [15:0]        mx;
	logic               trig_off;

	assign pm       = clamp_pct(cfg.att_main);
	assign ct       = clamp_pct(cfg.att_triggers);
	assign pt_full  = 27'(prod_pt_q) * 27'(Div100Mul);
	assign mx       = (weak_q > strong_q) ? weak_q : strong_q;
	assign trig_off = (cfg.trigger_mode == rcthr_pkg::TriggerModeOff);

	assign in_stall   = (state_q != F_IDLE);
	assign push_valid = (state_q == F_PUSH);
	assign push_cmd   = '{is_tick: is_tick_q, strong_lvl: lvl_s_q, weak_lvl: lvl_w_q,
		left: lvl_l_q, right: lvl_r_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					state_d = req_type ? F_PUSH : F_PT_MUL;
				end
			end
			F_PT_MUL:  state_d = F_PT_DIV;
			F_PT_DIV:  state_d = F_TRG_MUL;
			F_TRG_MUL: state_d = F_TRG_DIV;
			F_TRG_DIV: state_d = F_LVL_MUL;
			F_LVL_MUL: state_d = F_LVL_DIV;
			F_LVL_DIV: state_d = F_PUSH;
			F_PUSH: begin
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default:   state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					is_tick_q <= req_type;
					weak_q    <= weak_request;
					strong_q  <= strong_request;
					lz_q      <= left_trigger_pressure;
					rz_q      <= right_trigger_pressure;
				end
			end
			F_PT_MUL: begin
				prod_pt_q <= 14'(ct) * 14'(pm);
			end
			F_PT_DIV: begin
				pt_q <= rcthr_pkg::LevelW'(pt_full >> Div100Shft);
			end
			F_TRG_MUL: begin
				trg_l_q <= 17'(lz_q) * 17'(pt_q) + RoundTrig;
				trg_r_q <= 17'(rz_q) * 17'(pt_q) + RoundTrig;
			end
			F_TRG_DIV: begin
				tl_q <= trig_off ? '0 : div1023(trg_l_q);
				tr_q <= trig_off ? '0 : div1023(trg_r_q);
			end
			F_LVL_MUL: begin
				prod_s_q <= 23'(strong_q) * 23'(pm) + RoundLvl;
				prod_w_q <= 23'(weak_q) * 23'(pm) + RoundLvl;
				prod_l_q <= 23'(mx) * 23'(tl_q) + RoundLvl;
				prod_r_q <= 23'(mx) * 23'(tr_q) + RoundLvl;
			end
			F_LVL_DIV: begin
				lvl_s_q <= div65535(prod_s_q);
				lvl_w_q <= div65535(prod_w_q);
				lvl_l_q <= div65535(prod_l_q);
				lvl_r_q <= div65535(prod_r_q);
			end
			default: begin
			end
		endcase
	end

endmodule

/* sv/rcthr_queue.sv */
// ----------------------------------------------------------------------------
// Rumble throttler command queue
// Small register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rcthr_queue #(
	parameter int DEPTH = rcthr_pkg::QueueDepthDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  rcthr_pkg::cmd_t push_cmd,
	output logic            pop_valid,
	input  logic            pop_ready,
	output rcthr_pkg::cmd_t pop_cmd
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

	rcthr_pkg::cmd_t entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push, do_pop;

	assign push_ready = (count_q != Full);
	assign pop_valid  = (count_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* sv/rcthr_back.sv */
// ----------------------------------------------------------------------------
// Rumble throttler back end
// Keeps the pending and shadow levels and the countdowns, runs one queued
// command per cycle unless a report stalls, and registers the motor report.
// ----------------------------------------------------------------------------
module rcthr_back #(
	parameter int MAX_DELAY_TICKS = rcthr_pkg::MaxDelayTicksDefault
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rcthr_pkg::cfg_t   cfg,
	input  logic              pop_valid,
	output logic              pop_ready,
	input  rcthr_pkg::cmd_t   pop_cmd,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [3:0]        motor_enable_mask,
	output rcthr_pkg::level_t strong_level,
	output rcthr_pkg::level_t weak_level,
	output rcthr_pkg::level_t left_level,
	output rcthr_pkg::level_t right_level,
	output logic [7:0]        pulse_sustain,
	output logic [7:0]        pulse_loops
);

	localparam int TW = rcthr_pkg::TicksW;
	localparam logic [TW-1:0] MaxDelay = TW'(MAX_DELAY_TICKS);

	function automatic logic [3:0] exchange_bits(input logic [3:0] v, input logic [1:0] a,
		input logic [1:0] b);
		logic [3:0] r;
		r    = v;
		r[a] = v[b];
		r[b] = v[a];
		return r;
	endfunction

	rcthr_pkg::level_t pend_q [4];
	rcthr_pkg::level_t shadow_q [4];
	logic              sched_q;
	logic [TW-1:0]     send_cnt_q, thr_cnt_q;
	logic              out_valid_q;

	rcthr_pkg::level_t req_lvl [4];
	rcthr_pkg::level_t pend_upd [4];
	rcthr_pkg::level_t cmp_l, cmp_r;
	logic [3:0]        en_raw, en1, en2, en3;
	logic [TW-1:0]     thr_dec, cnt_dec, delay;
	logic              do_pop, send, report;
	logic              no_trig;

	assign req_lvl[0] = pop_cmd.strong_lvl;
	assign req_lvl[1] = pop_cmd.weak_lvl;
	assign req_lvl[2] = pop_cmd.left;
	assign req_lvl[3] = pop_cmd.right;
	assign no_trig    = cfg.quirk_flags[rcthr_pkg::QuirkNoTrigger];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (pop_cmd.is_tick) begin
				pend_upd[i] = pend_q[i];
			end else if (req_lvl[i] == '0) begin
				pend_upd[i] = '0;
			end else begin
				pend_upd[i] = (req_lvl[i] > pend_q[i]) ? req_lvl[i] : pend_q[i];
			end
		end
	end

	assign cmp_l = no_trig ? '0 : pend_upd[2];
	assign cmp_r = no_trig ? '0 : pend_upd[3];

	assign en_raw[0] = (pend_upd[1] != shadow_q[1]);
	assign en_raw[1] = (pend_upd[0] != shadow_q[0]);
	assign en_raw[2] = !no_trig && (cmp_r != shadow_q[3]);
	assign en_raw[3] = !no_trig && (cmp_l != shadow_q[2]);

	assign en1 = cfg.quirk_flags[rcthr_pkg::QuirkNoMask] ? 4'hF : en_raw;
	assign en2 = cfg.quirk_flags[rcthr_pkg::QuirkReverse] ?
		exchange_bits(exchange_bits(en1, 2'd1, 2'd2), 2'd0, 2'd3) : en1;
	assign en3 = cfg.quirk_flags[rcthr_pkg::QuirkSwap] ?
		exchange_bits(exchange_bits(en2, 2'd0, 2'd2), 2'd1, 2'd3) : en2;

	assign thr_dec = (thr_cnt_q != '0) ? thr_cnt_q - 1'b1 : thr_cnt_q;
	assign cnt_dec = (send_cnt_q != '0) ? send_cnt_q - 1'b1 : send_cnt_q;
	assign delay   = (thr_cnt_q > MaxDelay) ? MaxDelay : thr_cnt_q;

	assign send   = pop_cmd.is_tick ? (sched_q && cnt_dec == '0)
		: (!sched_q && delay == '0);
	assign report = send && (en_raw != '0);

	assign pop_ready = !out_valid_q || !out_stall;
	assign do_pop    = pop_valid && pop_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				pend_q[i]   <= '0;
				shadow_q[i] <= '0;
			end
			sched_q     <= 1'b0;
			send_cnt_q  <= '0;
			thr_cnt_q   <= rcthr_pkg::ThrottleReset;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_ready) begin
				out_valid_q <= do_pop && report;
			end
			if (do_pop) begin
				if (pop_cmd.is_tick) begin
					thr_cnt_q <= thr_dec;
					if (sched_q) begin
						send_cnt_q <= cnt_dec;
					end
				end else begin
					for (int i = 0; i < 4; i++) begin
						pend_q[i] <= pend_upd[i];
					end
					if (!sched_q && delay != '0) begin
						sched_q    <= 1'b1;
						send_cnt_q <= delay;
					end
				end
				if (send) begin
					sched_q <= 1'b0;
				end
				if (report) begin
					for (int i = 0; i < 4; i++) begin
						shadow_q[i] <= pend_upd[i];
						pend_q[i]   <= '0;
					end
					thr_cnt_q <= cfg.throttle_ticks;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pop && report) begin
			motor_enable_mask <= en3;
			strong_level      <= pend_upd[0];
			weak_level        <= pend_upd[1];
			left_level        <= cmp_l;
			right_level       <= cmp_r;
			pulse_sustain     <= cfg.quirk_flags[rcthr_pkg::QuirkNoPulse] ? 8'd0
				: rcthr_pkg::PulseSustainOn;
			pulse_loops       <= cfg.quirk_flags[rcthr_pkg::QuirkNoPulse] ? 8'd0
				: rcthr_pkg::LoopCountOn;
		end
	end

endmodule
